// ===== rtl/generational_handle_allocator_unit_macros.svh =====
// Assertion macros shared by the allocator's checker.
// Plain text macros; no dependencies.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while arst_n is low.
`define GHU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet while arst_n is low.
`define GHU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ghu_pkg.sv =====
// Package for the generational handle allocator: field widths, request and
// status codes, sequencer state and operation types. No dependencies.
package ghu_pkg;

	localparam int REQ_W        = 2;
	localparam int STATUS_W     = 2;
	localparam int IDX_FIELD_W  = 12;
	localparam int VER_FIELD_W  = 16;
	localparam int LIVE_FIELD_W = 12;

	localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ALIVE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_BUMP,
		ST_CHECK,
		ST_FINISH
	} ghu_state_t;

	// what the finishing cycle commits to state
	typedef enum logic [1:0] {
		OP_NONE,
		OP_FRESH,
		OP_REUSE,
		OP_RETIRE
	} ghu_op_t;

endpackage

// ===== rtl/ghu_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies.
module ghu_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/generational_handle_allocator_unit.sv =====
// Generational handle allocator: hands out {index, version} handles, retires them
// through a LIFO free stack and answers liveness queries; slot 0 is never issued.
// One word in, one word out per request, one request in flight at a time. A fresh
// create, a full create, an out-of-range handle or request code 3 goes straight to
// FINISH; destroy/query of an in-range handle passes through CHECK (one slot RAM
// read); a create that reuses a freed index passes through POP and BUMP (free stack
// read, then slot RAM read at the popped index). These serialized RAM reads set the rate.
// A finished result sits in the output register, so the next word is taken while it
// waits; the request finishes only once the output register is free. Alive marks live
// next to the versions in the slot RAM and are trusted only below the fresh-index
// counter, so reset needs no clearing pass and the block is ready right after reset.
module generational_handle_allocator_unit #(
	parameter int MAX_SLOTS    = 4096,
	parameter int VERSION_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ghu_pkg::REQ_W-1:0]          req_type,
	input  logic [ghu_pkg::IDX_FIELD_W-1:0]    entity_index,
	input  logic [ghu_pkg::VER_FIELD_W-1:0]    entity_version,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ghu_pkg::STATUS_W-1:0]       status,
	output logic [ghu_pkg::IDX_FIELD_W-1:0]    out_index,
	output logic [ghu_pkg::VER_FIELD_W-1:0]    out_version,
	output logic                               is_alive,
	output logic [ghu_pkg::LIVE_FIELD_W-1:0]   live_total
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int NF_W   = IDX_W + 1;          // counters that can hold MAX_SLOTS itself
	localparam int SLOT_W = VERSION_BITS + 1;   // {alive mark, version}
	localparam int CMP_W  = (NF_W > ghu_pkg::IDX_FIELD_W) ? NF_W : ghu_pkg::IDX_FIELD_W;
	localparam int VX_W   = (VERSION_BITS > ghu_pkg::VER_FIELD_W) ?
	                        VERSION_BITS : ghu_pkg::VER_FIELD_W;
	localparam int IX_W   = (IDX_W > ghu_pkg::IDX_FIELD_W) ? IDX_W : ghu_pkg::IDX_FIELD_W;
	localparam logic [NF_W-1:0] NF_LIMIT = NF_W'(MAX_SLOTS);

	// sequencer and request registers
	ghu_pkg::ghu_state_t state_q, state_nxt;
	ghu_pkg::ghu_op_t    op_q;
	logic [ghu_pkg::REQ_W-1:0]       req_q;
	logic [ghu_pkg::VER_FIELD_W-1:0] ver_q;
	logic [IDX_W-1:0]                slot_q;
	logic [VERSION_BITS-1:0]         nv_q;      // version to write back / report
	logic [ghu_pkg::STATUS_W-1:0]    res_status_q;
	logic                            res_alive_q;

	// allocator bookkeeping
	logic [NF_W-1:0]  free_top_q;
	logic [NF_W-1:0]  next_fresh_q;
	logic [IDX_W-1:0] live_q;

	// output register
	logic                               out_valid_q;
	logic [ghu_pkg::STATUS_W-1:0]       status_q;
	logic [ghu_pkg::IDX_FIELD_W-1:0]    out_index_q;
	logic [ghu_pkg::VER_FIELD_W-1:0]    out_version_q;
	logic                               is_alive_q;
	logic [ghu_pkg::LIVE_FIELD_W-1:0]   live_total_q;

	// RAM ports
	logic              slot_we, slot_re;
	logic [IDX_W-1:0]  slot_waddr, slot_raddr;
	logic [SLOT_W-1:0] slot_wdata, slot_rdata;
	logic              stack_we, stack_re;
	logic [IDX_W-1:0]  stack_waddr, stack_raddr;
	logic [IDX_W-1:0]  stack_wdata, stack_rdata;

	// helpers
	logic                    in_acc, fire;
	logic [CMP_W-1:0]        idx_ext, nf_ext;
	logic                    idx_in_range, stack_empty, fresh_ok;
	logic [NF_W-1:0]         top_dec;
	logic                    rd_mark, ver_match;
	logic [VERSION_BITS-1:0] rd_ver;
	logic [VX_W-1:0]         rd_ver_x, req_ver_x, nv_x;
	logic [IX_W-1:0]         slot_ix, live_ix;
	logic [IDX_W-1:0]        live_nxt;
	logic                    issues_handle;

	// input closes while a request is in flight
	assign in_stall     = (state_q != ghu_pkg::ST_IDLE);
	assign in_acc       = in_valid && !in_stall;
	assign fire         = (state_q == ghu_pkg::ST_FINISH) && (!out_valid_q || !out_stall);
	assign idx_ext      = CMP_W'(entity_index);
	assign nf_ext       = CMP_W'(next_fresh_q);
	// index 0 and anything at or past the fresh counter are dead by definition
	assign idx_in_range = (idx_ext != '0) && (idx_ext < nf_ext);
	assign stack_empty  = (free_top_q == '0);
	assign fresh_ok     = (next_fresh_q < NF_LIMIT);
	assign top_dec      = free_top_q - NF_W'(1);

	assign rd_mark   = slot_rdata[VERSION_BITS];
	assign rd_ver    = slot_rdata[VERSION_BITS-1:0];
	// compare at the wider of the two widths, so short versions never alias
	assign rd_ver_x  = VX_W'(rd_ver);
	assign req_ver_x = VX_W'(ver_q);
	assign ver_match = (rd_ver_x == req_ver_x);

	assign nv_x          = VX_W'(nv_q);
	assign slot_ix       = IX_W'(slot_q);
	assign live_ix       = IX_W'(live_nxt);
	assign issues_handle = (op_q == ghu_pkg::OP_FRESH) || (op_q == ghu_pkg::OP_REUSE);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ghu_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (req_type) inside
						ghu_pkg::REQ_CREATE: begin
							state_nxt = stack_empty ? ghu_pkg::ST_FINISH : ghu_pkg::ST_POP;
						end
						ghu_pkg::REQ_DESTROY, ghu_pkg::REQ_QUERY: begin
							state_nxt = idx_in_range ? ghu_pkg::ST_CHECK : ghu_pkg::ST_FINISH;
						end
						default: begin
							state_nxt = ghu_pkg::ST_FINISH;
						end
					endcase
				end
			end
			ghu_pkg::ST_POP:    state_nxt = ghu_pkg::ST_BUMP;
			ghu_pkg::ST_BUMP:   state_nxt = ghu_pkg::ST_FINISH;
			ghu_pkg::ST_CHECK:  state_nxt = ghu_pkg::ST_FINISH;
			ghu_pkg::ST_FINISH: state_nxt = fire ? ghu_pkg::ST_IDLE : ghu_pkg::ST_FINISH;
			default:            state_nxt = ghu_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: RAM strobes and the committed live count
	always_comb begin
		stack_re    = (state_q == ghu_pkg::ST_IDLE) && in_acc &&
		              (req_type == ghu_pkg::REQ_CREATE) && !stack_empty;
		stack_raddr = top_dec[IDX_W-1:0];

		slot_re     = ((state_q == ghu_pkg::ST_IDLE) && in_acc && idx_in_range &&
		               ((req_type == ghu_pkg::REQ_DESTROY) || (req_type == ghu_pkg::REQ_QUERY))) ||
		              (state_q == ghu_pkg::ST_POP);
		slot_raddr  = (state_q == ghu_pkg::ST_POP) ? stack_rdata : idx_ext[IDX_W-1:0];

		// all state writes happen in the finishing cycle
		slot_we     = fire && (op_q != ghu_pkg::OP_NONE);
		slot_waddr  = slot_q;
		slot_wdata  = {op_q != ghu_pkg::OP_RETIRE, nv_q};

		stack_we    = fire && (op_q == ghu_pkg::OP_RETIRE);
		stack_waddr = free_top_q[IDX_W-1:0];
		stack_wdata = slot_q;

		case (op_q)
			ghu_pkg::OP_FRESH,
			ghu_pkg::OP_REUSE:  live_nxt = live_q + IDX_W'(1);
			ghu_pkg::OP_RETIRE: live_nxt = live_q - IDX_W'(1);
			default:            live_nxt = live_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ghu_pkg::ST_IDLE;
			free_top_q   <= '0;
			next_fresh_q <= NF_W'(1);
			live_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (fire) begin
				out_valid_q <= 1'b1;
				live_q      <= live_nxt;
				case (op_q)
					ghu_pkg::OP_FRESH:  next_fresh_q <= next_fresh_q + NF_W'(1);
					ghu_pkg::OP_REUSE:  free_top_q   <= top_dec;
					ghu_pkg::OP_RETIRE: free_top_q   <= free_top_q + NF_W'(1);
					default:            ;
				endcase
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ghu_pkg::ST_IDLE: begin
				if (in_acc) begin
					req_q       <= req_type;
					ver_q       <= entity_version;
					slot_q      <= idx_ext[IDX_W-1:0];
					nv_q        <= '0;
					res_alive_q <= 1'b0;
					op_q        <= ghu_pkg::OP_NONE;
					case (req_type) inside
						ghu_pkg::REQ_CREATE: begin
							if (!stack_empty) begin
								op_q         <= ghu_pkg::OP_REUSE;
								res_status_q <= ghu_pkg::STATUS_OK;
							end else if (fresh_ok) begin
								op_q         <= ghu_pkg::OP_FRESH;
								slot_q       <= next_fresh_q[IDX_W-1:0];
								res_status_q <= ghu_pkg::STATUS_OK;
							end else begin
								res_status_q <= ghu_pkg::STATUS_FULL;
							end
						end
						ghu_pkg::REQ_DESTROY, ghu_pkg::REQ_QUERY: begin
							res_status_q <= ghu_pkg::STATUS_NOT_ALIVE;
						end
						default: begin
							res_status_q <= ghu_pkg::STATUS_OK;
						end
					endcase
				end
			end
			ghu_pkg::ST_POP: begin
				slot_q <= stack_rdata;
			end
			ghu_pkg::ST_BUMP: begin
				nv_q <= rd_ver + VERSION_BITS'(1);   // wraps at the version width
			end
			ghu_pkg::ST_CHECK: begin
				nv_q <= rd_ver;
				if (rd_mark && ver_match) begin
					res_alive_q  <= 1'b1;
					res_status_q <= ghu_pkg::STATUS_OK;
					if (req_q == ghu_pkg::REQ_DESTROY) begin
						op_q <= ghu_pkg::OP_RETIRE;
					end
				end
			end
			default: ;
		endcase
	end

	// output payload
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= res_status_q;
			out_index_q   <= issues_handle ? slot_ix[ghu_pkg::IDX_FIELD_W-1:0] : '0;
			out_version_q <= issues_handle ? nv_x[ghu_pkg::VER_FIELD_W-1:0] : '0;
			is_alive_q    <= res_alive_q;
			live_total_q  <= live_ix[ghu_pkg::LIVE_FIELD_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_index   = out_index_q;
	assign out_version = out_version_q;
	assign is_alive    = is_alive_q;
	assign live_total  = live_total_q;

	// per-slot {alive mark, version}
	ghu_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// LIFO of freed indices
	ghu_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_SLOTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stack_we),
		.waddr (stack_waddr),
		.wdata (stack_wdata),
		.re    (stack_re),
		.raddr (stack_raddr),
		.rdata (stack_rdata)
	);

endmodule

// ===== rtl/ghu_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on ghu_pkg and generational_handle_allocator_unit_macros.svh.
`include "generational_handle_allocator_unit_macros.svh"

module ghu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [ghu_pkg::STATUS_W-1:0]       status,
	input logic [ghu_pkg::IDX_FIELD_W-1:0]    out_index,
	input logic [ghu_pkg::VER_FIELD_W-1:0]    out_version,
	input logic                               is_alive,
	input logic [ghu_pkg::LIVE_FIELD_W-1:0]   live_total
);

	// one request in flight: a taken word closes the input
	`GHU_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")

	`GHU_ASSERT_IMP(a_full_no_handle, out_valid && status == ghu_pkg::STATUS_FULL, out_index == '0 && out_version == '0 && !is_alive, "full create returned a handle")

	`GHU_ASSERT_IMP(a_dead_clean, out_valid && status == ghu_pkg::STATUS_NOT_ALIVE, out_index == '0 && out_version == '0 && !is_alive, "dead handle word not clean")

	`GHU_ASSERT_IMP(a_handle_is_create, out_valid && out_index != '0, status == ghu_pkg::STATUS_OK && !is_alive, "issued handle with bad status")

	`GHU_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_index) && $stable(live_total), "stalled result changed")

endmodule

bind generational_handle_allocator_unit ghu_checker u_ghu_checker (.*);
